// ----- sv/abdt_pkg.sv -----
package abdt_pkg;

  localparam int ANCHOR_COUNT = 2254;
  localparam int GRID0_END    = 1568;
  localparam int GRID1_END    = 1960;
  localparam int LOGIT_CLAMP  = 25600;
  localparam int CORNER_MAX   = 8388607;
  localparam int CORNER_MIN   = -8388608;
  // quotient bits below the saturation point
  localparam int QBITS        = 23;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_NET_W     = 3'd1;
  localparam logic [2:0] REG_NET_H     = 3'd2;
  localparam logic [2:0] REG_SCALE     = 3'd3;
  localparam logic [2:0] REG_PAD_X     = 3'd4;
  localparam logic [2:0] REG_PAD_Y     = 3'd5;

  typedef struct packed {
    logic [11:0]        anchor_index;
    logic signed [23:0] score_logit;
    logic signed [23:0] delta_x;
    logic signed [23:0] delta_y;
    logic signed [23:0] delta_w;
    logic signed [23:0] delta_h;
  } in_t;

  typedef struct packed {
    logic [11:0]        kept_index;
    logic signed [15:0] kept_logit;
    logic signed [23:0] left_edge;
    logic signed [23:0] top_edge;
    logic signed [23:0] right_edge;
    logic signed [23:0] bottom_edge;
  } out_t;

  typedef struct packed {
    logic signed [15:0] score_threshold_logit;
    logic [12:0]        net_input_width;
    logic [12:0]        net_input_height;
    logic [14:0]        frame_scale;
    logic [14:0]        pad_offset_x;
    logic [14:0]        pad_offset_y;
  } cfg_t;

  typedef struct packed {
    logic [4:0] gx;
    logic [4:0] gy;
    logic [1:0] gk;   // grid size is 7 << gk
  } cell_t;

  typedef struct packed {
    logic [11:0]        idx;
    logic signed [15:0] logit;
    logic signed [23:0] dx;
    logic signed [23:0] dy;
    logic signed [23:0] dw;
    logic signed [23:0] dh;
    cell_t              pos;
  } item_t;

  function automatic logic [12:0] net_eff(input logic [12:0] n);
    net_eff = (n == 13'd0) ? 13'd1 : n;
  endfunction

  // cell coordinates from the anchor index; divisions by 3 and 7 via reciprocals
  function automatic cell_t anchor_cell(input logic [11:0] idx);
    logic [11:0] r;
    logic [9:0]  c;
    logic [9:0]  t;
    logic [19:0] p;
    logic [9:0]  span;
    logic [9:0]  rem;
    cell_t       res;
    if (idx < 12'(GRID0_END)) begin
      res.gk = 2'd2;
      r = idx;
      c = r[10:1];
    end else if (idx < 12'(GRID1_END)) begin
      res.gk = 2'd1;
      r = idx - 12'(GRID0_END);
      c = r[10:1];
    end else begin
      res.gk = 2'd0;
      r = idx - 12'(GRID1_END);
      p = 20'(r[10:1]) * 20'd171;
      c = p[18:9];
    end
    t = c >> res.gk;
    p = 20'(t) * 20'd293;
    res.gy = p[15:11];
    span = 10'd7 << res.gk;
    rem = c - 10'(res.gy) * span;
    res.gx = rem[4:0];
    anchor_cell = res;
  endfunction

endpackage

// ----- sv/abdt_regs.sv -----
module abdt_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output abdt_pkg::cfg_t    cfg
);

  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.score_threshold_logit <= 16'sd0;
      cfg.net_input_width       <= 13'd224;
      cfg.net_input_height      <= 13'd224;
      cfg.frame_scale           <= 15'd640;
      cfg.pad_offset_x          <= 15'd0;
      cfg.pad_offset_y          <= 15'd0;
    end else if (wr) begin
      case (paddr[4:2])
        abdt_pkg::REG_THRESHOLD: cfg.score_threshold_logit <= pwdata[15:0];
        abdt_pkg::REG_NET_W:     cfg.net_input_width       <= pwdata[12:0];
        abdt_pkg::REG_NET_H:     cfg.net_input_height      <= pwdata[12:0];
        abdt_pkg::REG_SCALE:     cfg.frame_scale           <= pwdata[14:0];
        abdt_pkg::REG_PAD_X:     cfg.pad_offset_x          <= pwdata[14:0];
        abdt_pkg::REG_PAD_Y:     cfg.pad_offset_y          <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      abdt_pkg::REG_THRESHOLD: prdata = 32'(cfg.score_threshold_logit);
      abdt_pkg::REG_NET_W:     prdata = 32'(cfg.net_input_width);
      abdt_pkg::REG_NET_H:     prdata = 32'(cfg.net_input_height);
      abdt_pkg::REG_SCALE:     prdata = 32'(cfg.frame_scale);
      abdt_pkg::REG_PAD_X:     prdata = 32'(cfg.pad_offset_x);
      abdt_pkg::REG_PAD_Y:     prdata = 32'(cfg.pad_offset_y);
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

// ----- sv/abdt_front.sv -----
module abdt_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  abdt_pkg::in_t   in_data,
  input  abdt_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            q_push,
  output abdt_pkg::item_t q_item
);

  logic               accept;
  logic               keep;
  logic signed [15:0] lclamp;
  logic               hold_valid;
  abdt_pkg::item_t    hold;

  always_comb begin
    if (in_data.score_logit > 24'(abdt_pkg::LOGIT_CLAMP))
      lclamp = 16'(abdt_pkg::LOGIT_CLAMP);
    else if (in_data.score_logit < -24'(abdt_pkg::LOGIT_CLAMP))
      lclamp = -16'(abdt_pkg::LOGIT_CLAMP);
    else
      lclamp = in_data.score_logit[15:0];
  end

  assign keep = (in_data.anchor_index < 12'(abdt_pkg::ANCHOR_COUNT)) &&
                (lclamp >= cfg.score_threshold_logit) &&
                (in_data.delta_w > 24'sd0) && (in_data.delta_h > 24'sd0) &&
                (cfg.frame_scale != 15'd0);

  assign in_stall = hold_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = hold_valid && !q_full;
  assign q_item   = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (!q_full) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold.idx   <= in_data.anchor_index;
      hold.logit <= lclamp;
      hold.dx    <= in_data.delta_x;
      hold.dy    <= in_data.delta_y;
      hold.dw    <= in_data.delta_w;
      hold.dh    <= in_data.delta_h;
      hold.pos   <= abdt_pkg::anchor_cell(in_data.anchor_index);
    end
  end

endmodule

// ----- sv/abdt_queue.sv -----
module abdt_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  abdt_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output abdt_pkg::item_t head_item
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  abdt_pkg::item_t entries [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push)
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !do_pop)
        count <= count + 1'b1;
      else if (do_pop && !push)
        count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      entries[wr_ptr] <= push_item;
  end

endmodule

// ----- sv/abdt_back.sv -----
module abdt_back (
  input  logic            clk,
  input  logic            rst,
  input  abdt_pkg::cfg_t  cfg,
  input  logic            q_valid,
  output logic            q_pop,
  input  abdt_pkg::item_t q_item,
  output logic            out_valid,
  input  logic            out_stall,
  output abdt_pkg::out_t  out_data
);

  localparam int NS = abdt_pkg::QBITS;

  logic en;

  logic [12:0] nn  [2];
  logic [15:0] dd  [2];   // 7 * network size
  logic [14:0] pad [2];

  assign nn[0]  = abdt_pkg::net_eff(cfg.net_input_width);
  assign nn[1]  = abdt_pkg::net_eff(cfg.net_input_height);
  assign dd[0]  = (16'(nn[0]) << 3) - 16'(nn[0]);
  assign dd[1]  = (16'(nn[1]) << 3) - 16'(nn[1]);
  assign pad[0] = cfg.pad_offset_x;
  assign pad[1] = cfg.pad_offset_y;

  assign en    = !(out_valid && out_stall);
  assign q_pop = en && q_valid;

  // stage A: request taken from the queue
  logic            va;
  abdt_pkg::item_t ia;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= q_valid;
  end
  always_ff @(posedge clk) begin
    if (en) ia <= q_item;
  end

  // stage B: center terms; corner c is left, top, right, bottom
  logic signed [31:0] tb_next [4];
  logic [27:0]        pn_next [2];
  logic signed [31:0] tb [4];
  logic [27:0]        pn [2];
  logic               vb;
  logic [1:0]         kb;
  logic [11:0]        ib;
  logic signed [15:0] lb;

  always_comb begin
    logic signed [31:0] d;
    logic signed [31:0] sz;
    logic [4:0]         g;
    logic signed [31:0] d7;
    logic signed [31:0] s7;
    logic [18:0]        anc;
    logic signed [31:0] base;
    logic signed [31:0] szg;
    for (int a = 0; a < 2; a++) begin
      d  = (a == 0) ? 32'(ia.dx) : 32'(ia.dy);
      sz = (a == 0) ? 32'(ia.dw) : 32'(ia.dh);
      g  = (a == 0) ? ia.pos.gx : ia.pos.gy;
      d7 = (d <<< 3) - d;
      s7 = (sz <<< 3) - sz;
      anc = 19'({g, 1'b1}) * 19'(nn[a]);
      base = (d7 <<< (3'(ia.pos.gk) + 3'd1)) + $signed({5'd0, anc, 8'd0});
      szg = s7 <<< ia.pos.gk;
      tb_next[a]     = base - szg;
      tb_next[a + 2] = base + szg;
      pn_next[a] = 28'(pad[a]) * 28'(nn[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tb <= tb_next;
      pn <= pn_next;
      kb <= ia.pos.gk;
      ib <= ia.idx;
      lb <= ia.logit;
    end
  end

  // stage C: scale and subtract padding
  logic signed [47:0] nc_next [4];
  logic signed [47:0] nc [4];
  logic               vc;
  logic [1:0]         kc;
  logic [11:0]        ic;
  logic signed [15:0] lc;

  always_comb begin
    logic signed [47:0] s48;
    logic [47:0]        p7;
    logic [47:0]        pt;
    s48 = 48'($signed({1'b0, cfg.frame_scale}));
    for (int c = 0; c < 4; c++) begin
      p7 = (48'(pn[c % 2]) << 3) - 48'(pn[c % 2]);
      pt = p7 << (4'd9 + 4'(kb));
      nc_next[c] = s48 * 48'(tb[c]) - $signed(pt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      nc <= nc_next;
      kc <= kb;
      ic <= ib;
      lc <= lb;
    end
  end

  // divide pipeline: stage 0 holds the folded dividend, one quotient bit per stage
  logic              vs  [NS+1];
  logic [11:0]       is  [NS+1];
  logic signed [15:0] ls [NS+1];
  logic [38:0]       rem [NS+1][4];
  logic [NS-1:0]     qs  [NS+1][4];
  logic              ng  [NS+1][4];
  logic              st  [NS+1][4];

  logic [38:0] rem0_next [4];
  logic        ng0_next  [4];
  logic        st0_next  [4];

  always_comb begin
    logic signed [48:0] x;
    logic signed [48:0] v;
    logic [48:0]        u;
    logic [48:0]        den;
    for (int c = 0; c < 4; c++) begin
      den = 49'(dd[c % 2]) << (4'd5 + 4'(kc));
      x = (49'(nc[c]) <<< 1) + $signed(den);
      v = x >>> (4'd6 + 4'(kc));
      ng0_next[c] = v[48];
      u = v[48] ? ~v : v;
      st0_next[c] = (u >= (49'(dd[c % 2]) << NS));
      rem0_next[c] = u[38:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vs[0] <= 1'b0;
    else if (en) vs[0] <= vc;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      is[0] <= ic;
      ls[0] <= lc;
      for (int c = 0; c < 4; c++) begin
        rem[0][c] <= rem0_next[c];
        qs[0][c]  <= '0;
        ng[0][c]  <= ng0_next[c];
        st[0][c]  <= st0_next[c];
      end
    end
  end

  for (genvar j = 0; j < NS; j++) begin : g_div
    always_ff @(posedge clk) begin
      if (rst) vs[j+1] <= 1'b0;
      else if (en) vs[j+1] <= vs[j];
    end
    always_ff @(posedge clk) begin
      logic [38:0] sub;
      if (en) begin
        is[j+1] <= is[j];
        ls[j+1] <= ls[j];
        for (int c = 0; c < 4; c++) begin
          sub = 39'(dd[c % 2]) << (NS - 1 - j);
          if (rem[j][c] >= sub) begin
            rem[j+1][c] <= rem[j][c] - sub;
            qs[j+1][c]  <= {qs[j][c][NS-2:0], 1'b1};
          end else begin
            rem[j+1][c] <= rem[j][c];
            qs[j+1][c]  <= {qs[j][c][NS-2:0], 1'b0};
          end
          ng[j+1][c] <= ng[j][c];
          st[j+1][c] <= st[j][c];
        end
      end
    end
  end

  // output register: sign restore and saturation
  logic signed [23:0] edge_next [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      if (st[NS][c])
        edge_next[c] = ng[NS][c] ? 24'(abdt_pkg::CORNER_MIN) : 24'(abdt_pkg::CORNER_MAX);
      else if (ng[NS][c])
        edge_next[c] = ~{1'b0, qs[NS][c]};
      else
        edge_next[c] = {1'b0, qs[NS][c]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vs[NS];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      out_data.kept_index  <= is[NS];
      out_data.kept_logit  <= ls[NS];
      out_data.left_edge   <= edge_next[0];
      out_data.top_edge    <= edge_next[1];
      out_data.right_edge  <= edge_next[2];
      out_data.bottom_edge <= edge_next[3];
    end
  end

endmodule

// ----- sv/anchor_box_decode_threshold.sv -----
// Anchor box decoder with score threshold.
// Input channel (in_valid / in_stall / in_data): one detector candidate per
// request. Output channel (out_valid / out_stall / out_data): one decoded box
// per kept candidate; candidates with an out-of-range anchor, a clamped logit
// below the threshold, an empty box or a zero frame scale produce nothing.
// Registers are written over the APB port; the user must do so only while no
// candidate is in flight, the block itself does not enforce this. Throughput:
// one candidate per clock while in_stall is low. The front classifies and
// registers each candidate, a small queue decouples it from the back pipeline,
// which performs the corner arithmetic and a restoring divide by 7*network
// size, one quotient bit per stage over 23 stages.
// A stall on the output freezes the back pipeline; the queue then fills and
// in_stall rises once the queue and the front register are full.
// Reset (rst, synchronous) empties the pipeline and queue and loads the
// register defaults.
module anchor_box_decode_threshold #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  abdt_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output abdt_pkg::out_t out_data,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [4:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  abdt_pkg::cfg_t  cfg;
  logic            q_full;
  logic            q_push;
  abdt_pkg::item_t q_in;
  logic            q_pop;
  logic            q_valid;
  abdt_pkg::item_t q_out;

  abdt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  abdt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  abdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_item  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_out)
  );

  abdt_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_out),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
